>>> src/lrupr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared field widths, capacity reset value, controller state and command types.
// ----------------------------------------------------------------------------
package lrupr_pkg;

	localparam int PAGE_W = 32;
	localparam int CNT_W  = 32;
	localparam int CAP_W  = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EXEC
	} lrupr_state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} lrupr_cmd_t;

endpackage
`default_nettype wire

>>> src/lrupr_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LRU page replacement channels
// Request, response and capacity write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface lrupr_req_if import lrupr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [PAGE_W-1:0] page;
	logic              last_request;

	modport source (output valid, output page, output last_request, input ready);
	modport sink (input valid, input page, input last_request, output ready);
endinterface

interface lrupr_rsp_if import lrupr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              hit;
	logic              evicted_valid;
	logic [PAGE_W-1:0] evicted_page;
	logic [CNT_W-1:0]  hit_count;

	modport source (output valid, output hit, output evicted_valid, output evicted_page,
		output hit_count, input ready);
	modport sink (input valid, input hit, input evicted_valid, input evicted_page,
		input hit_count, output ready);
endinterface

interface lrupr_cfg_if import lrupr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] capacity;

	modport source (output valid, output capacity, input ready);
	modport sink (input valid, input capacity, output ready);
endinterface
`default_nettype wire

>>> src/lrupr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LRU page replacement controller
// Sequences request capture and the store update, and owns the response valid.
// ----------------------------------------------------------------------------
module lrupr_ctrl import lrupr_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   req_valid,
	output logic        req_ready,
	output logic        rsp_valid,
	input  wire logic   rsp_ready,
	output lrupr_cmd_t  cmd
);

	lrupr_state_t state_q, state_d;
	logic         rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule
`default_nettype wire

>>> src/lrupr_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LRU page replacement datapath
// Page slots with ages, parallel tag compare, victim and free slot selection.
// ----------------------------------------------------------------------------
module lrupr_dp import lrupr_pkg::*; #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lrupr_cmd_t        cmd,
	input  wire logic [PAGE_W-1:0] req_page,
	input  wire logic              req_last,
	input  wire logic              cfg_fire,
	input  wire logic [CAP_W-1:0]  cfg_capacity,
	output logic                   hit,
	output logic                   evicted_valid,
	output logic [PAGE_W-1:0]      evicted_page,
	output logic [CNT_W-1:0]       hit_count
);

	localparam int AGE_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
	localparam logic [7:0] MAX_CNT = 8'(MAX_ENTRIES);

	logic [PAGE_W-1:0]      page_q [MAX_ENTRIES];
	logic [AGE_W-1:0]       age_q  [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [OCC_W-1:0]       occ_q;
	logic [CNT_W-1:0]       hits_q;
	logic [CAP_W-1:0]       cap_q;

	logic [PAGE_W-1:0]      req_page_s1;
	logic                   req_last_s1;

	logic                   hit_q;
	logic                   ev_valid_q;
	logic [PAGE_W-1:0]      ev_page_q;
	logic [CNT_W-1:0]       count_q;

	logic [MAX_ENTRIES-1:0] match_v, oldest_v, free_v, first_free_v, target_v;
	logic [AGE_W-1:0]       hit_age, old_age;
	logic [PAGE_W-1:0]      old_page;
	logic [7:0]             occ_ext, cap_ext, eff_cap;
	logic                   do_hit, do_evict;
	logic [CNT_W-1:0]       hits_next;

	always_comb begin
		occ_ext  = 8'(occ_q);
		cap_ext  = {3'b000, cap_q};
		if (cap_q == '0) begin
			eff_cap = 8'd1;
		end else if (cap_ext > MAX_CNT) begin
			eff_cap = MAX_CNT;
		end else begin
			eff_cap = cap_ext;
		end
		old_age  = AGE_W'(occ_q - OCC_W'(1));
		hit_age  = '0;
		old_page = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			match_v[i]  = valid_q[i] && (page_q[i] == req_page_s1);
			oldest_v[i] = valid_q[i] && (age_q[i] == old_age);
			free_v[i]   = !valid_q[i];
			if (match_v[i]) begin
				hit_age = hit_age | age_q[i];
			end
			if (oldest_v[i]) begin
				old_page = old_page | page_q[i];
			end
		end
		do_hit       = |match_v;
		do_evict     = !do_hit && (occ_ext >= eff_cap) && (occ_q != '0);
		first_free_v = free_v & (~free_v + MAX_ENTRIES'(1));
		target_v     = do_evict ? oldest_v : first_free_v;
		hits_next    = (do_hit && (hits_q != '1)) ? hits_q + CNT_W'(1) : hits_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			age_q   <= '{default: '0};
			occ_q   <= '0;
			hits_q  <= '0;
			cap_q   <= CAP_RESET;
		end else begin
			if (cfg_fire) begin
				cap_q <= cfg_capacity;
			end
			if (cmd.exec) begin
				if (req_last_s1) begin
					valid_q <= '0;
					age_q   <= '{default: '0};
					occ_q   <= '0;
					hits_q  <= '0;
				end else begin
					for (int i = 0; i < MAX_ENTRIES; i++) begin
						if (do_hit) begin
							if (match_v[i]) begin
								age_q[i] <= '0;
							end else if (valid_q[i] && (age_q[i] < hit_age)) begin
								age_q[i] <= age_q[i] + AGE_W'(1);
							end
						end else if (target_v[i]) begin
							valid_q[i] <= 1'b1;
							age_q[i]   <= '0;
						end else if (valid_q[i]) begin
							age_q[i] <= age_q[i] + AGE_W'(1);
						end
					end
					hits_q <= hits_next;
					if (!do_hit && !do_evict) begin
						occ_q <= occ_q + OCC_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_page_s1 <= req_page;
			req_last_s1 <= req_last;
		end
		if (cmd.exec) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (!do_hit && target_v[i]) begin
					page_q[i] <= req_page_s1;
				end
			end
			hit_q      <= do_hit;
			ev_valid_q <= do_evict;
			ev_page_q  <= do_evict ? old_page : '0;
			count_q    <= hits_next;
		end
	end

	assign hit           = hit_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;
	assign hit_count     = count_q;

endmodule
`default_nettype wire

>>> src/lru_page_replacement_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LRU page replacement core
// Fully associative least-recently-used page store with hit and eviction report.
// ----------------------------------------------------------------------------
// Each request beat first has its page captured; in the update that follows,
// all slots are compared in parallel, the victim or free slot is chosen and the
// ages are updated. No new request is taken until that update is done, and the
// update waits while an earlier response is untaken. The response sits in an
// output register, and a new request is captured while it waits. The capacity
// register may be written only while no request is in flight; a request marked
// as last clears the store and the hit count after its response is formed.
module lru_page_replacement_core import lrupr_pkg::*; #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	lrupr_req_if.sink   req,
	lrupr_rsp_if.source rsp,
	lrupr_cfg_if.sink   cfg
);

	lrupr_cmd_t cmd;

	assign cfg.ready = 1'b1;

	lrupr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	lrupr_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.req_page      (req.page),
		.req_last      (req.last_request),
		.cfg_fire      (cfg.valid && cfg.ready),
		.cfg_capacity  (cfg.capacity),
		.hit           (rsp.hit),
		.evicted_valid (rsp.evicted_valid),
		.evicted_page  (rsp.evicted_page),
		.hit_count     (rsp.hit_count)
	);

	a_exec_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> rsp.valid)
		else $error("update did not present a response");

	a_load_exec_apart: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.exec))
		else $error("capture and update in the same cycle");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.hit && rsp.evicted_valid))
		else $error("hit response reports an eviction");

	a_no_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.evicted_valid) |-> (rsp.evicted_page == '0))
		else $error("evicted page not zero without eviction");

endmodule
`default_nettype wire

>>> tb/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LRU page replacement core testbench
// Drives page requests and capacity writes into the core and checks every
// response beat against a scoreboard predictor of the least-recently-used store.
// Directed cases come first, then random request sequences under several
// capacities and handshake idling patterns, including a long output stall.
// ----------------------------------------------------------------------------
module testbench;
	import lrupr_pkg::*;

	localparam int MAX_SLOTS  = 16;
	localparam int HOLD_LEN   = 300;
	localparam int FIFO_DEPTH = 64;
	localparam int POOL_MAX   = 20;

	typedef struct packed {
		logic              hit;
		logic              evicted_valid;
		logic [PAGE_W-1:0] evicted_page;
		logic [CNT_W-1:0]  hit_count;
	} lru_reply_t;

	logic clk = 1'b0;
	logic arst_n;

	lrupr_req_if req_ch();
	lrupr_rsp_if rsp_ch();
	lrupr_cfg_if cfg_ch();

	lru_page_replacement_core #(.MAX_ENTRIES(MAX_SLOTS)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	logic [PAGE_W-1:0] store_page [MAX_SLOTS];
	logic              store_valid [MAX_SLOTS];
	int                store_age [MAX_SLOTS];
	int                store_fill;
	logic [CNT_W-1:0]  seq_hits;
	int                cap_reg;

	lru_reply_t reply_fifo [FIFO_DEPTH];
	int reply_wr = 0;
	int reply_rd = 0;
	int mismatches = 0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int unsigned hold_starts = 0;
	int unsigned hold_seen = 0;
	int hold_left = 0;

	logic [PAGE_W-1:0] page_pool [POOL_MAX];
	int pool_len = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic void clear_store();
		for (int i = 0; i < MAX_SLOTS; i++) begin
			store_page[i] = '0;
			store_valid[i] = 1'b0;
			store_age[i] = 0;
		end
		store_fill = 0;
		seq_hits = '0;
	endfunction

	function automatic lru_reply_t predict_access(input logic [PAGE_W-1:0] pg, input logic last);
		lru_reply_t r;
		int found;
		int victim;
		int eff;
		int oldest;
		r = '0;
		found = -1;
		victim = -1;
		oldest = 0;
		eff = (cap_reg == 0) ? 1 : ((cap_reg > MAX_SLOTS) ? MAX_SLOTS : cap_reg);
		for (int i = 0; i < MAX_SLOTS; i++)
			if (found < 0 && store_valid[i] && store_page[i] == pg)
				found = i;
		if (found >= 0) begin
			r.hit = 1'b1;
			if (seq_hits != '1)
				seq_hits = seq_hits + CNT_W'(1);
			for (int i = 0; i < MAX_SLOTS; i++)
				if (store_valid[i] && store_age[i] < store_age[found])
					store_age[i]++;
			store_age[found] = 0;
		end else begin
			if (store_fill >= eff) begin
				for (int i = 0; i < MAX_SLOTS; i++)
					if (store_valid[i] && (victim < 0 || store_age[i] > oldest)) begin
						victim = i;
						oldest = store_age[i];
					end
				if (victim >= 0) begin
					r.evicted_valid = 1'b1;
					r.evicted_page = store_page[victim];
					store_valid[victim] = 1'b0;
					store_fill--;
				end
			end
			if (victim < 0)
				for (int i = 0; i < MAX_SLOTS; i++)
					if (victim < 0 && !store_valid[i])
						victim = i;
			if (victim >= 0) begin
				for (int i = 0; i < MAX_SLOTS; i++)
					if (store_valid[i])
						store_age[i]++;
				store_page[victim] = pg;
				store_valid[victim] = 1'b1;
				store_age[victim] = 0;
				store_fill++;
			end
		end
		r.hit_count = seq_hits;
		if (last)
			clear_store();
		return r;
	endfunction

	// The receiver either idles at random or sits out a long hold-off that
	// the stimulus side requests by bumping hold_starts.
	always @(posedge clk) begin
		if (hold_starts != hold_seen) begin
			hold_seen = hold_starts;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		lru_reply_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (reply_wr == reply_rd) begin
				$error("response beat with no request outstanding");
				mismatches++;
			end else begin
				want = reply_fifo[reply_rd % FIFO_DEPTH];
				reply_rd++;
				if (rsp_ch.hit !== want.hit) begin
					$error("hit: expected %0h, got %0h", want.hit, rsp_ch.hit);
					mismatches++;
				end
				if (rsp_ch.evicted_valid !== want.evicted_valid) begin
					$error("evicted_valid: expected %0h, got %0h",
						want.evicted_valid, rsp_ch.evicted_valid);
					mismatches++;
				end
				if (rsp_ch.evicted_page !== want.evicted_page) begin
					$error("evicted_page: expected %0h, got %0h",
						want.evicted_page, rsp_ch.evicted_page);
					mismatches++;
				end
				if (rsp_ch.hit_count !== want.hit_count) begin
					$error("hit_count: expected %0h, got %0h",
						want.hit_count, rsp_ch.hit_count);
					mismatches++;
				end
			end
		end
	end

	task automatic send_request(input logic [PAGE_W-1:0] pg, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.page <= pg;
		req_ch.last_request <= last;
		reply_fifo[reply_wr % FIFO_DEPTH] = predict_access(pg, last);
		reply_wr++;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (reply_wr != reply_rd)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_capacity(input int value);
		wait_drained();
		cfg_ch.valid <= 1'b1;
		cfg_ch.capacity <= value[CAP_W-1:0];
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		cap_reg = value;
	endtask

	task automatic test_hits_and_misses();
		send_request(32'h0000_0000, 1'b0);
		send_request(32'hFFFF_FFFF, 1'b0);
		send_request(32'h0000_0000, 1'b0);
		send_request(32'hFFFF_FFFF, 1'b0);
		send_request(32'h0000_0005, 1'b1);
		send_request(32'h0000_0000, 1'b0);
	endtask

	task automatic test_eviction_order();
		set_capacity(2);
		send_request(32'hA5A5_0001, 1'b0);
		send_request(32'h5A5A_0002, 1'b0);
		send_request(32'hA5A5_0001, 1'b0);
		send_request(32'h0000_0C03, 1'b0);
		send_request(32'h5A5A_0002, 1'b0);
		send_request(32'h0000_0C03, 1'b1);
	endtask

	task automatic test_capacity_zero();
		set_capacity(0);
		send_request(32'h0000_0007, 1'b0);
		send_request(32'h0000_0008, 1'b0);
		send_request(32'h0000_0008, 1'b0);
		send_request(32'h0000_0007, 1'b1);
	endtask

	task automatic test_capacity_shrink();
		set_capacity(16);
		send_request(32'h1000_0000, 1'b0);
		send_request(32'h2000_0000, 1'b0);
		send_request(32'h3000_0000, 1'b0);
		send_request(32'h4000_0000, 1'b0);
		set_capacity(2);
		send_request(32'h5000_0000, 1'b0);
		send_request(32'h3000_0000, 1'b1);
	endtask

	task automatic refill_pool();
		pool_len = $urandom_range(1, POOL_MAX);
		for (int i = 0; i < pool_len; i++)
			page_pool[i] = $urandom;
	endtask

	task automatic send_random(input int count);
		logic [PAGE_W-1:0] pg;
		logic last;
		for (int k = 0; k < count; k++) begin
			if (pool_len == 0)
				refill_pool();
			if ($urandom_range(99) < 80)
				pg = page_pool[$urandom_range(pool_len - 1)];
			else
				pg = $urandom;
			last = ($urandom_range(29) == 0);
			send_request(pg, last);
			if (last)
				refill_pool();
		end
	endtask

	task automatic test_random_traffic();
		int caps[11] = '{16, 1, 4, 31, 0, 7, 17, 2, 12, 3, 16};
		for (int p = 0; p < 11; p++) begin
			set_capacity(caps[p]);
			if (p < 4) begin
				send_idle_pct = 15;
				recv_idle_pct = 81;
			end else if (p < 8) begin
				send_idle_pct = 81;
				recv_idle_pct = 15;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			send_random(100);
		end
	endtask

	task automatic test_output_stall();
		set_capacity(5);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_starts <= hold_starts + 1;
		send_random(40);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.page = '0;
		req_ch.last_request = 1'b0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.capacity = '0;
		clear_store();
		cap_reg = int'(CAP_RESET);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_hits_and_misses();
		test_eviction_order();
		test_capacity_zero();
		test_capacity_shrink();
		test_random_traffic();
		test_output_stall();

		wait_drained();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire
